@@ rtl/ckm_pkg.sv @@
// Shared types, constants and character helpers for the command keyword matcher.
`default_nettype none
package ckm_pkg;

	localparam int NUM_KEYWORDS_MAX = 6;
	localparam int NUM_KEYWORDS_DEF = 6;
	localparam int MAX_LINE_DEF     = 256;

	localparam int CHAR_W   = 8;
	localparam int WORD_W   = 32;
	localparam int IDX_W    = 3;
	localparam int OFFSET_W = 8;
	localparam int MO_W     = 3;
	localparam int REG_IDX_W = 3;

	localparam logic [IDX_W-1:0]  NO_MATCH   = 3'd6;
	localparam logic [MO_W-1:0]   MO_LIMIT   = 3'd4;

	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CHAR_UC_A  = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_UC_Z  = 8'h5A;
	localparam logic [CHAR_W-1:0] CASE_BIAS  = 8'h20;

	// Keyword words after reset: HELP, GO, MEM, DIS, FILL, CRC
	localparam logic [WORD_W-1:0] KW_RESET [NUM_KEYWORDS_MAX] = '{
		32'd1347175752, 32'd20295, 32'd5064013,
		32'd5458244, 32'd1280067910, 32'd4411971
	};

	typedef struct packed {
		logic                alive;
		logic                matched;
		logic                settled;
		logic [OFFSET_W-1:0] param_pos;
	} lane_stat_t;

	typedef struct packed {
		logic                emit;
		logic [IDX_W-1:0]    index;
		logic [OFFSET_W-1:0] offset;
	} pick_t;

	function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
		return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? c + CASE_BIAS : c;
	endfunction

	function automatic logic is_blank(input logic [CHAR_W-1:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB);
	endfunction

	// Folded byte k of a keyword word; zero at and beyond the first zero byte.
	function automatic logic [CHAR_W-1:0] key_byte(input logic [WORD_W-1:0] word,
		input logic [MO_W-1:0] k);
		logic [CHAR_W-1:0] b;
		logic              ended;
		logic [CHAR_W-1:0] res;
		ended = 1'b0;
		res   = '0;
		for (int j = 0; j < 4; j++) begin
			b = word[CHAR_W*j +: CHAR_W];
			if (k == MO_W'(j) && !ended)
				res = fold(b);
			if (b == CHAR_NUL)
				ended = 1'b1;
		end
		return res;
	endfunction

endpackage
`default_nettype wire

@@ rtl/ckm_lane.sv @@
// One keyword lane: byte compare against the current character and per-line match state.
`default_nettype none
module ckm_lane (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               step,
	input  wire                               rearm,
	input  wire  [ckm_pkg::WORD_W-1:0]        keyword,
	input  wire  [ckm_pkg::CHAR_W-1:0]        ch,
	input  wire  [ckm_pkg::MO_W-1:0]          mo,
	input  wire  [ckm_pkg::OFFSET_W-1:0]      pos,
	output ckm_pkg::lane_stat_t               stat_next
);
	import ckm_pkg::*;

	lane_stat_t        stat_q;
	logic [CHAR_W-1:0] ref_byte;

	always_comb begin
		ref_byte  = key_byte(keyword, mo);
		stat_next = stat_q;
		if (stat_q.alive) begin
			if (ref_byte == CHAR_NUL || ch == CHAR_DOT) begin
				stat_next.alive   = 1'b0;
				stat_next.matched = 1'b1;
			end else if (fold(ch) != ref_byte) begin
				stat_next.alive = 1'b0;
			end
		end
		// first non-blank character after the match point opens the parameters
		if (stat_next.matched && !stat_q.settled && !is_blank(ch)) begin
			stat_next.settled   = 1'b1;
			stat_next.param_pos = pos;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stat_q <= '{alive: 1'b1, matched: 1'b0, settled: 1'b0, param_pos: '0};
		end else if (rearm) begin
			stat_q <= '{alive: 1'b1, matched: 1'b0, settled: 1'b0, param_pos: '0};
		end else if (step) begin
			stat_q <= stat_next;
		end
	end

endmodule
`default_nettype wire

@@ rtl/ckm_select.sv @@
// Priority pick of the winning keyword over the lane states.
`default_nettype none
module ckm_select #(
	parameter int NUM_KEYWORDS = ckm_pkg::NUM_KEYWORDS_DEF
) (
	input  ckm_pkg::lane_stat_t stat [NUM_KEYWORDS],
	output ckm_pkg::pick_t      pick
);
	import ckm_pkg::*;

	logic found;

	always_comb begin
		found = 1'b0;
		pick  = '{emit: 1'b0, index: NO_MATCH, offset: '0};
		for (int i = 0; i < NUM_KEYWORDS; i++) begin
			if (!found) begin
				if (stat[i].alive) begin
					found = 1'b1;
				end else if (stat[i].matched) begin
					found = 1'b1;
					if (stat[i].settled) begin
						pick.emit   = 1'b1;
						pick.index  = IDX_W'(i);
						pick.offset = stat[i].param_pos;
					end
				end
			end
		end
		// every keyword dead: no-match at once
		if (!found)
			pick = '{emit: 1'b1, index: NO_MATCH, offset: '0};
	end

endmodule
`default_nettype wire

@@ rtl/command_keyword_matcher.sv @@
// Top level of the command keyword matcher: input stage, line control and result register.
// A taken character waits in the input stage until it can advance; its result, if any,
// is then loaded into the output register, which drives m_tvalid.
// Throughput: one character per cycle; the input stage holds only while a result waits.
// Reset (arst_n low, asynchronous): keywords return to HELP, GO, MEM, DIS, FILL, CRC,
// the block waits for the start of a line, and both stages are emptied.
`default_nettype none
module command_keyword_matcher #(
	parameter int NUM_KEYWORDS = ckm_pkg::NUM_KEYWORDS_DEF,
	parameter int MAX_LINE     = ckm_pkg::MAX_LINE_DEF
) (
	input  wire                              clk,
	input  wire                              arst_n,
	// character stream in
	input  wire                              s_tvalid,
	output logic                             s_tready,
	input  wire  [7:0]                       s_tdata,   // [7:0] char_in
	// result stream out
	output logic                             m_tvalid,
	input  wire                              m_tready,
	output logic [15:0]                      m_tdata,   // [2:0] command_index, [10:3] params_offset
	// keyword register writes
	input  wire                              cfg_we,
	input  wire  [ckm_pkg::REG_IDX_W-1:0]    cfg_index,
	input  wire  [ckm_pkg::WORD_W-1:0]       cfg_data
);
	import ckm_pkg::*;

	localparam int POS_W = $clog2(MAX_LINE);
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_LINE - 1);

	// line phases
	localparam logic [1:0] PH_LEAD   = 2'd0;   // skipping leading blanks
	localparam logic [1:0] PH_MATCH  = 2'd1;   // comparing against the keywords
	localparam logic [1:0] PH_IGNORE = 2'd2;   // result given, wait for the NUL

	// register indexes of the configuration port
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_1 = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_2 = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_3 = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_4 = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_KEYWORD_5 = 3'd5;

	logic [WORD_W-1:0]   kw_q [NUM_KEYWORDS_MAX];

	logic                s1_valid_s1;
	logic [CHAR_W-1:0]   char_s1;

	logic [1:0]          phase_q;
	logic [POS_W-1:0]    pos_q;
	logic [MO_W-1:0]     mo_q;

	logic                out_valid_q;
	logic [IDX_W-1:0]    out_index_q;
	logic [OFFSET_W-1:0] out_offset_q;

	logic                advance;
	logic                blank;
	logic                matching;
	logic                emit;
	logic                rearm;
	logic [MO_W-1:0]     mo_eff;
	logic [POS_W-1:0]    pos_inc;
	lane_stat_t          stat_next [NUM_KEYWORDS];
	pick_t               pick;

	// ---------------------------------------------------------------------
	// Keyword registers: a write to an index past the list is dropped.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYWORDS_MAX; i++)
				kw_q[i] <= KW_RESET[i];
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_KEYWORD_0: kw_q[0] <= cfg_data;
				REG_KEYWORD_1: kw_q[1] <= cfg_data;
				REG_KEYWORD_2: kw_q[2] <= cfg_data;
				REG_KEYWORD_3: kw_q[3] <= cfg_data;
				REG_KEYWORD_4: kw_q[4] <= cfg_data;
				REG_KEYWORD_5: kw_q[5] <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Input stage. The character in it is processed when the output register
	// is free or being emptied this cycle; a new transaction is taken whenever
	// the stage is empty or moves on.
	// ---------------------------------------------------------------------
	assign advance  = s1_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !s1_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_s1 <= 1'b1;
		end else if (advance) begin
			s1_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			char_s1 <= s_tdata;
	end

	// ---------------------------------------------------------------------
	// Line control. The first non-blank character is compared in the same
	// cycle as it leaves the leading blanks, at keyword byte zero.
	// ---------------------------------------------------------------------
	assign blank    = is_blank(char_s1);
	assign matching = (phase_q == PH_MATCH) || (phase_q == PH_LEAD && !blank);
	assign mo_eff   = (phase_q == PH_LEAD) ? '0 : mo_q;
	assign emit     = matching && pick.emit;
	assign pos_inc  = (pos_q != POS_MAX) ? pos_q + POS_W'(1) : pos_q;

	// NUL rearms either while waiting after a result or on the step that gives it
	assign rearm = advance && (char_s1 == CHAR_NUL)
	             && ((phase_q == PH_IGNORE) || emit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_LEAD;
			pos_q   <= '0;
			mo_q    <= '0;
		end else if (advance) begin
			unique case (phase_q) inside
				PH_IGNORE: begin
					if (rearm) begin
						phase_q <= PH_LEAD;
						pos_q   <= '0;
						mo_q    <= '0;
					end
				end
				PH_LEAD, PH_MATCH: begin
					if (!matching) begin
						pos_q <= pos_inc;
					end else if (rearm) begin
						phase_q <= PH_LEAD;
						pos_q   <= '0;
						mo_q    <= '0;
					end else if (emit) begin
						phase_q <= PH_IGNORE;
					end else begin
						phase_q <= PH_MATCH;
						pos_q   <= pos_inc;
						mo_q    <= (mo_eff < MO_LIMIT) ? mo_eff + MO_W'(1) : mo_eff;
					end
				end
				default: phase_q <= PH_LEAD;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Keyword lanes and the priority pick
	// ---------------------------------------------------------------------
	for (genvar g = 0; g < NUM_KEYWORDS; g++) begin : g_lane
		ckm_lane u_lane (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (advance && matching),
			.rearm     (rearm),
			.keyword   (kw_q[g]),
			.ch        (char_s1),
			.mo        (mo_eff),
			.pos       (OFFSET_W'(pos_q)),
			.stat_next (stat_next[g])
		);
	end

	ckm_select #(
		.NUM_KEYWORDS (NUM_KEYWORDS)
	) u_select (
		.stat (stat_next),
		.pick (pick)
	);

	// ---------------------------------------------------------------------
	// Result register: load on a result, drop the valid once taken.
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_index_q  <= pick.index;
			out_offset_q <= pick.offset;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'b0, out_offset_q, out_index_q};

	// ---------------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------------
	a_lead_offset_zero : assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_LEAD) |-> (mo_q == '0))
		else $error("keyword byte offset not cleared while skipping leading blanks");

	a_result_then_wait : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && char_s1 != CHAR_NUL) |=> (phase_q == PH_IGNORE))
		else $error("line not closed after its result");

	a_stage_holds : assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_s1 && out_valid_q && !m_tready) |=> (s1_valid_s1 && $stable(char_s1)))
		else $error("input stage lost its character while the result waited");

	a_no_match_offset : assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && pick.index == NO_MATCH) |=> (m_tvalid && m_tdata[10:3] == '0))
		else $error("no-match result carries a parameter offset");

endmodule
`default_nettype wire

@@ sim/ckm_result_checker.sv @@
// Result checker for the command keyword matcher: tracks keyword writes, predicts and compares.
`timescale 1ns / 1ps
module ckm_result_checker (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            s_tvalid,
	input  wire                            s_tready,
	input  wire  [7:0]                     s_tdata,   // [7:0] char_in
	input  wire                            m_tvalid,
	input  wire                            m_tready,
	input  wire  [15:0]                    m_tdata,   // [2:0] command_index, [10:3] params_offset
	input  wire                            cfg_we,
	input  wire  [ckm_pkg::REG_IDX_W-1:0]  cfg_index,
	input  wire  [ckm_pkg::WORD_W-1:0]     cfg_data,
	output int                             fail_count,
	output int                             results_owed
);
	import ckm_pkg::*;

	typedef enum logic [1:0] {SCAN_LEAD, SCAN_KEY, SCAN_SKIP} scan_phase_t;

	typedef struct packed {
		logic [IDX_W-1:0]    command;
		logic [OFFSET_W-1:0] offset;
	} command_hit_t;

	logic [WORD_W-1:0]           keyword_word [NUM_KEYWORDS_MAX];
	scan_phase_t                 scan_phase;
	logic [OFFSET_W-1:0]         line_pos;
	logic [MO_W-1:0]             key_col;
	logic [NUM_KEYWORDS_MAX-1:0] alive;
	logic [NUM_KEYWORDS_MAX-1:0] matched;
	logic [NUM_KEYWORDS_MAX-1:0] settled;
	logic [OFFSET_W-1:0]         param_at [NUM_KEYWORDS_MAX];
	command_hit_t                owed_commands [$];

	function automatic logic [7:0] lower_char(input logic [7:0] c);
		return (c >= CHAR_UC_A && c <= CHAR_UC_Z) ? (c | CASE_BIAS) : c;
	endfunction

	function automatic logic blank_char(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c == CHAR_TAB);
	endfunction

	// Folded keyword character at a column; NUL once the keyword has ended.
	function automatic logic [7:0] keyword_char(input logic [WORD_W-1:0] word, input int col);
		if (col >= 4)
			return CHAR_NUL;
		for (int j = 0; j < col; j++)
			if (word[8*j +: 8] == CHAR_NUL)
				return CHAR_NUL;
		return lower_char(word[8*col +: 8]);
	endfunction

	task automatic rearm_line();
		scan_phase = SCAN_LEAD;
		line_pos   = '0;
		key_col    = '0;
		alive      = '1;
		matched    = '0;
		settled    = '0;
		for (int i = 0; i < NUM_KEYWORDS_MAX; i++)
			param_at[i] = '0;
	endtask

	task automatic bump_pos();
		if (line_pos < MAX_LINE_DEF - 1)
			line_pos = line_pos + 1'b1;
	endtask

	task automatic report_miss(input string what, input int want, input int got);
		$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
		fail_count = fail_count + 1;
	endtask

	task automatic match_char(input logic [7:0] c);
		logic [7:0]          lc;
		logic [7:0]          kc;
		logic [OFFSET_W-1:0] pos;
		logic                decided;
		logic                emit;
		command_hit_t        hit;
		lc          = lower_char(c);
		pos         = line_pos;
		decided     = 1'b0;
		emit        = 1'b0;
		hit.command = NO_MATCH;
		hit.offset  = '0;
		if (scan_phase == SCAN_SKIP) begin
			if (c == CHAR_NUL)
				rearm_line();
			return;
		end
		if (scan_phase == SCAN_LEAD) begin
			if (blank_char(c)) begin
				bump_pos();
				return;
			end
			scan_phase = SCAN_KEY;
			key_col    = '0;
		end
		for (int i = 0; i < NUM_KEYWORDS_DEF; i++) begin
			if (alive[i]) begin
				kc = keyword_char(keyword_word[i], int'(key_col));
				if (kc == CHAR_NUL || c == CHAR_DOT) begin
					alive[i]   = 1'b0;
					matched[i] = 1'b1;
				end else if (lc != kc) begin
					alive[i] = 1'b0;
				end
			end
			if (matched[i] && !settled[i] && !blank_char(c)) begin
				settled[i]  = 1'b1;
				param_at[i] = pos;
			end
		end
		// the lowest keyword still in play decides; it must be settled to report
		for (int i = 0; i < NUM_KEYWORDS_DEF && !decided; i++) begin
			if (alive[i]) begin
				decided = 1'b1;
			end else if (matched[i]) begin
				decided = 1'b1;
				if (settled[i]) begin
					emit        = 1'b1;
					hit.command = IDX_W'(i);
					hit.offset  = param_at[i];
				end
			end
		end
		if (!decided)
			emit = 1'b1;
		if (key_col < MO_LIMIT)
			key_col = key_col + 1'b1;
		if (emit) begin
			owed_commands.push_back(hit);
			if (c == CHAR_NUL)
				rearm_line();
			else
				scan_phase = SCAN_SKIP;
		end else begin
			bump_pos();
		end
	endtask

	task automatic check_result(input logic [15:0] word);
		command_hit_t want;
		if (owed_commands.size() == 0) begin
			report_miss("unexpected result, command_index", NO_MATCH + 1, word[2:0]);
			return;
		end
		want = owed_commands.pop_front();
		if (word[2:0] != want.command)
			report_miss("command_index", want.command, word[2:0]);
		if (word[10:3] != want.offset)
			report_miss("params_offset", want.offset, word[10:3]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_KEYWORDS_MAX; i++)
				keyword_word[i] = KW_RESET[i];
			rearm_line();
			owed_commands.delete();
			fail_count = 0;
			results_owed <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(m_tdata);
			// a keyword write lands after the character of the same edge
			if (s_tvalid && s_tready)
				match_char(s_tdata);
			if (cfg_we && cfg_index < NUM_KEYWORDS_MAX)
				keyword_word[cfg_index] = cfg_data;
			results_owed <= owed_commands.size();
		end
	end

endmodule

@@ sim/tb_command_keyword_matcher.sv @@
// Testbench top for the command keyword matcher: stimulus, keyword writes and verdict.
`timescale 1ns / 1ps
module tb_command_keyword_matcher;
	import ckm_pkg::*;

	localparam int KEYWORD_REGS   = NUM_KEYWORDS_MAX;
	localparam int REG_SLOTS      = 1 << REG_IDX_W;
	localparam int SETTLE_CYCLES  = 6;
	localparam int RANDOM_CHARS   = 600;
	localparam int NARROW_SPAN    = 5;
	localparam int LONG_LEAD_LO   = 250;
	localparam int LONG_LEAD_HI   = 300;

	// Keyword table stages; the later ones are random tables
	localparam int STAGE_RESET_TABLE = 0;
	localparam int STAGE_EMPTY_KEYS  = 1;
	localparam int STAGE_FULL_BYTES  = 2;

	localparam logic [7:0] CHAR_DIGIT_0  = 8'h30;
	localparam logic [7:0] CHAR_DIGIT_9  = 8'h39;
	localparam logic [7:0] CHAR_LC_A     = 8'h61;
	localparam logic [7:0] CHAR_LC_Z     = 8'h7A;
	localparam logic [7:0] CHAR_PRINT_LO = 8'h21;
	localparam logic [7:0] CHAR_PRINT_HI = 8'h7E;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [7:0]           s_tdata;    // [7:0] char_in
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;    // [2:0] command_index, [10:3] params_offset
	logic                 cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	int                   fail_count;
	int                   results_owed;

	// Stimulus side copy of the keyword table, used to build lines that match
	logic [WORD_W-1:0]    kw_table [KEYWORD_REGS];
	logic [7:0]           line_buf [$];
	int                   chars_counted;
	int                   stall_left;
	bit                   feed_steady;
	bit                   sink_steady;

	command_keyword_matcher dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	ckm_result_checker hit_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.fail_count   (fail_count),
		.results_owed (results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Hard stop in case a handshake never completes
	initial begin
		#6_000_000;
		$display("timeout: matcher stopped moving transactions");
		$display("CHECK FAILED");
		$finish;
	end

	// Idle length shared by both sides: mostly none, often short, now and then long
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Result side: stall m_tready in random bursts, with calm stretches now and then
	initial begin
		m_tready    <= 1'b0;
		stall_left  = 0;
		sink_steady = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 199) == 0)
				sink_steady = !sink_steady;
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else begin
				m_tready <= 1'b1;
				if (!sink_steady)
					stall_left = idle_len();
			end
		end
	end

	function automatic logic [7:0] flip_case(input logic [7:0] c);
		if (((c >= CHAR_UC_A && c <= CHAR_UC_Z) || (c >= CHAR_LC_A && c <= CHAR_LC_Z))
				&& $urandom_range(0, 1))
			return c ^ CASE_BIAS;
		return c;
	endfunction

	function automatic logic [7:0] pick_blank();
		return $urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB;
	endfunction

	function automatic logic [7:0] pick_letter();
		if ($urandom_range(0, 1))
			return flip_case(8'($urandom_range(CHAR_UC_A, CHAR_UC_A + NARROW_SPAN)));
		return flip_case(8'($urandom_range(CHAR_UC_A, CHAR_UC_Z)));
	endfunction

	// Keyword bytes: mostly letters, half of them from a narrow range so that keywords share prefixes
	function automatic logic [7:0] pick_key_byte();
		int r;
		r = $urandom_range(0, 9);
		if (r < 6)
			return pick_letter();
		if (r < 8)
			return 8'($urandom_range(CHAR_DIGIT_0, CHAR_DIGIT_9));
		return 8'($urandom_range(1, 255));
	endfunction

	function automatic logic [7:0] pick_param_char();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return pick_blank();
		if (r == 1)
			return CHAR_DOT;
		return 8'($urandom_range(CHAR_PRINT_LO, CHAR_PRINT_HI));
	endfunction

	// Offer one character; hold s_tvalid high across back-to-back transactions
	task automatic send_char(input logic [7:0] c);
		int gap;
		gap = feed_steady ? 0 : idle_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= c;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// Send the buffered line and close it with a NUL
	task automatic send_buf();
		foreach (line_buf[i])
			send_char(line_buf[i]);
		send_char(CHAR_NUL);
		chars_counted += line_buf.size() + 1;
	endtask

	task automatic send_text(input string text);
		line_buf.delete();
		for (int i = 0; i < text.len(); i++)
			line_buf.push_back(text[i]);
		send_buf();
	endtask

	// Drop valid, wait for every owed result, then let the block settle
	task automatic quiesce();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (results_owed != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write the whole table while idle; spare indexes get junk that must be ignored
	task automatic write_table();
		quiesce();
		for (int slot = 0; slot < REG_SLOTS; slot++) begin
			cfg_we    <= 1'b1;
			cfg_index <= REG_IDX_W'(slot);
			cfg_data  <= (slot < KEYWORD_REGS) ? kw_table[slot] : $urandom();
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// Random table: junk after the terminating zero, some duplicates and prefixes
	task automatic random_table();
		int len;
		int src;
		for (int k = 0; k < KEYWORD_REGS; k++) begin
			kw_table[k] = $urandom();
			len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			for (int j = 0; j < len; j++)
				kw_table[k][8*j +: 8] = pick_key_byte();
			if (len < 4)
				kw_table[k][8*len +: 8] = CHAR_NUL;
			if (k > 0 && $urandom_range(0, 3) == 0) begin
				src = $urandom_range(0, k - 1);
				kw_table[k] = kw_table[src];
				if ($urandom_range(0, 1))
					kw_table[k][8*$urandom_range(1, 3) +: 8] = CHAR_NUL;
			end
		end
	endtask

	// Well-formed command line built from the live table, sometimes abbreviated or broken
	task automatic build_command_line();
		logic [7:0]        key [$];
		logic [WORD_W-1:0] word;
		int                lead;
		int                style;
		int                cut;
		line_buf.delete();
		lead = ($urandom_range(0, 39) == 0) ? $urandom_range(LONG_LEAD_LO, LONG_LEAD_HI)
		                                    : $urandom_range(0, 3);
		repeat (lead) line_buf.push_back(pick_blank());
		word = kw_table[$urandom_range(0, KEYWORD_REGS - 1)];
		for (int j = 0; j < 4 && word[8*j +: 8] != CHAR_NUL; j++)
			key.push_back(word[8*j +: 8]);
		style = $urandom_range(0, 9);
		if (style == 5 || style == 6) begin
			// abbreviation ended by a dot
			cut = $urandom_range(0, key.size());
			while (key.size() > cut)
				void'(key.pop_back());
			key.push_back(CHAR_DOT);
		end else if (style == 7 && key.size() > 0) begin
			key[$urandom_range(0, key.size() - 1)] = 8'($urandom_range(1, 255));
		end else if (style == 8 && key.size() > 0) begin
			cut = $urandom_range(0, key.size() - 1);
			while (key.size() > cut)
				void'(key.pop_back());
		end else if (style == 9) begin
			key.push_back(pick_letter());
		end
		foreach (key[i])
			line_buf.push_back(flip_case(key[i]));
		repeat ($urandom_range(0, 3)) line_buf.push_back(pick_blank());
		repeat ($urandom_range(0, 5)) line_buf.push_back(pick_param_char());
	endtask

	// Noise: any byte, blanks, dots and letters in no particular order
	task automatic build_noise_line();
		int r;
		line_buf.delete();
		repeat ($urandom_range(0, 12)) begin
			r = $urandom_range(0, 3);
			if (r == 0)
				line_buf.push_back(8'($urandom_range(0, 255)));
			else if (r == 1)
				line_buf.push_back(pick_blank());
			else if (r == 2)
				line_buf.push_back(CHAR_DOT);
			else
				line_buf.push_back(pick_letter());
		end
	endtask

	initial begin
		int stage;
		int stage_end;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_data  <= '0;
		arst_n    <= 1'b0;
		feed_steady   = 1'b0;
		chars_counted = 0;
		for (int k = 0; k < KEYWORD_REGS; k++)
			kw_table[k] = KW_RESET[k];
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed lines against the reset table
		send_text("HELP");          // full keyword closed by the NUL
		send_text("  go.  x");      // dot after a full keyword, behind leading blanks
		send_text("\tMeM\t 5");     // mixed case, tab blanks before the parameter
		send_text("h.");            // one-letter abbreviation
		send_text(".");             // a lone dot matches every keyword; the first wins
		send_text("xyz");           // all keywords dead at once
		send_text("");              // empty line
		send_text("   ");           // blanks only
		send_text("fillx");         // parameter straight after the keyword
		send_text("CR");            // prefix cut short by the NUL
		send_text("dis.crc 7");     // dot after a full keyword

		// Random part, table stage by table stage
		chars_counted = 0;
		stage = STAGE_RESET_TABLE;
		while (chars_counted < RANDOM_CHARS) begin
			if (stage == STAGE_EMPTY_KEYS) begin
				for (int k = 0; k < KEYWORD_REGS; k++)
					kw_table[k] = '0;
				write_table();
			end else if (stage == STAGE_FULL_BYTES) begin
				for (int k = 0; k < KEYWORD_REGS; k++)
					kw_table[k] = '1;
				write_table();
			end else if (stage != STAGE_RESET_TABLE) begin
				random_table();
				write_table();
			end
			stage_end = chars_counted
				+ ((stage == STAGE_EMPTY_KEYS || stage == STAGE_FULL_BYTES) ? 40 : 90);
			while (chars_counted < stage_end) begin
				feed_steady = ($urandom_range(0, 4) == 0);
				if ($urandom_range(0, 4) == 0)
					build_noise_line();
				else
					build_command_line();
				send_buf();
			end
			stage++;
		end

		quiesce();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
